// File: rtl/siloss_pkg.sv
// ----------------------------------------------------------------------------
// siloss_pkg: shared types and constants of the scale invariant log loss unit
// Holds the sequencer states, register indexes and fixed-point constants.
// ----------------------------------------------------------------------------
package siloss_pkg;

  // Configuration register indexes
  localparam logic CfgBatchSize = 1'b0;
  localparam logic CfgGamma     = 1'b1;

  // Reset values of the configuration registers
  localparam logic [10:0] BatchSizeRst = 11'd1;
  localparam logic [16:0] GammaRst     = 17'd32768;

  // ln(2) as unsigned Q0.32
  localparam logic [31:0] Ln2Q32 = 32'd2977044472;

  // Bias added to u*ln2, with u = log2(x) + 16 in Q.20: folds in the -16
  // offset, the half-LSB rounding and a positive offset of 2^58.
  localparam logic [58:0] LnBias = (59'd1 << 58) + (59'd1 << 35) - (59'd2977044472 << 24);

  // Digit-serial multiplier geometry
  localparam int unsigned MulAW    = 57;   // multiplicand width
  localparam int unsigned MulBW    = 40;   // multiplier width, 8-bit digits
  localparam logic [2:0]  MulSteps = 3'd5; // digits per product

  localparam int unsigned LogIters = 20;   // squarings per logarithm

  localparam logic [6:0] DivSteps = 7'd64; // quotient bits per division

  localparam logic signed [64:0] LossMax = 65'sd140737488355327;
  localparam logic signed [64:0] LossMin = -65'sd140737488355328;

  typedef enum logic [3:0] {
    S_IDLE,
    S_NORM,
    S_SQ,
    S_SCALE,
    S_DSQ,
    S_LAST,
    S_NSQ,
    S_GM1,
    S_GM2,
    S_DIV2,
    S_DIV1,
    S_OUT
  } state_e;

endpackage

// File: rtl/scale_invariant_log_loss_unit.sv
// ----------------------------------------------------------------------------
// scale_invariant_log_loss_unit: scale invariant log depth loss accumulator
// Sums log differences and their squares, emits the loss on the last item.
// ----------------------------------------------------------------------------
// Each input item carries a predicted and a target depth (unsigned Q16.16).
// The unit takes the natural log of each (Q6.16), accumulates d = ln(p) -
// ln(t) and d*d, and on an item with tlast set emits
// sum_sq/num - gamma*sum^2/num^2 as signed Q31.16 (saturated) with a flag
// telling whether any depth of the batch was zero; then it clears its sums.
// A batch_size of zero counts as one. Items are taken one at a time. All
// products run on one shared 57x8-bit digit-serial multiplier (five
// digits per product) and quotients on a one-bit-per-cycle divider. Each
// logarithm takes a leading-one normalization, twenty squarings and one
// scaling product; an item with a zero depth skips the logarithms. An
// item with tlast set adds three products and two 64-step divisions. The
// result sits in an output register, so the next item is taken while it
// waits.
module scale_invariant_log_loss_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [16:0] cfg_data_i,
  // Input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // [31:0] predicted_depth, [63:32] target_depth
  input  logic        s_axis_tlast,  // last_element
  // Result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // [47:0] loss_value
  output logic        m_axis_tuser   // [0] bad_input
);
  import siloss_pkg::*;

  state_e state_q, state_d;

  // Configuration
  logic [10:0] bs_q;
  logic [16:0] gm_q;

  // Latched item
  logic [31:0] targ_q, targ_d;
  logic        last_q, last_d;

  // Logarithm datapath
  logic [31:0] x_q, x_d;
  logic [4:0]  p_q, p_d;
  logic [19:0] frac_q, frac_d;
  logic [4:0]  it_q, it_d;
  logic        sel_q, sel_d;
  logic [22:0] lnp_q, lnp_d;
  logic signed [23:0] d_q, d_d;

  // Accumulators
  logic signed [39:0] dsum_q, dsum_d;
  logic [47:0] dsq_q, dsq_d;
  logic        err_q, err_d;

  // Finalization
  logic [39:0] smag_q, smag_d;
  logic [21:0] nsq_q, nsq_d;
  logic [63:0] term2_q, term2_d;
  logic [47:0] term1_q, term1_d;

  // Digit-serial multiplier
  logic [MulAW-1:0] ma_q, ma_d;
  logic [MulBW-1:0] mb_q, mb_d;
  logic [MulAW-1:0] mh_q, mh_d;
  logic [MulBW-1:0] ml_q, ml_d;
  logic [2:0]       mcnt_q, mcnt_d;
  logic [64:0]      mul_pp, mul_t;
  logic [96:0]      prod;
  logic             mul_done;

  // Serial divider
  logic [21:0] dr_q, dr_d;
  logic [63:0] dq_q, dq_d;
  logic [21:0] dv_q, dv_d;
  logic [6:0]  dcnt_q, dcnt_d;
  logic [22:0] div_rr;
  logic        div_ge;
  logic        div_done;

  // Output register
  logic        ovalid_q, ovalid_d;
  logic [47:0] loss_q, loss_d;
  logic        bad_q, bad_d;

  // Combinational helpers
  logic [10:0] num;
  logic [31:0] sq_m;
  logic        sq_bit;
  logic [58:0] ln_w;
  logic [22:0] ln_v;
  logic [31:0] sq_val;
  logic signed [40:0] dsum_s;
  logic [48:0] dsq_s;
  logic signed [64:0] loss_w;

  assign num = (bs_q == '0) ? 11'd1 : bs_q;

  // One multiplier digit: add multiplicand times the low digit, retire 8 bits
  assign mul_pp   = 65'(ma_q) * 65'(mb_q[7:0]);
  assign mul_t    = 65'(mh_q) + mul_pp;
  assign prod     = {mh_q, ml_q};
  assign mul_done = (mcnt_q == MulSteps);

  // Restoring division, one quotient bit per cycle
  assign div_rr   = {dr_q, dq_q[63]};
  assign div_ge   = (div_rr >= {1'b0, dv_q});
  assign div_done = (dcnt_q == DivSteps);

  // Squared mantissa back to Q1.31, halving when it reaches 2.0
  assign sq_bit = prod[63];
  assign sq_m   = sq_bit ? prod[63:32] : prod[62:31];

  // Scaled log with bias; the bias cancels in the difference
  assign ln_w = prod[58:0] + LnBias;
  assign ln_v = ln_w[58:36];

  assign sq_val = 32'((prod[47:0] + 48'h8000) >> 16);
  assign dsum_s = 41'(dsum_q) + 41'(d_q);
  assign dsq_s  = {1'b0, dsq_q} + 49'(sq_val);
  assign loss_w = $signed({17'b0, term1_q}) - $signed({1'b0, term2_q});

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = loss_q;
  assign m_axis_tuser  = bad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bs_q <= BatchSizeRst;
      gm_q <= GammaRst;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CfgBatchSize: bs_q <= cfg_data_i[10:0];
        CfgGamma:     gm_q <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      dsum_q   <= '0;
      dsq_q    <= '0;
      err_q    <= 1'b0;
      ovalid_q <= 1'b0;
      mcnt_q   <= '0;
      dcnt_q   <= '0;
    end else begin
      state_q  <= state_d;
      dsum_q   <= dsum_d;
      dsq_q    <= dsq_d;
      err_q    <= err_d;
      ovalid_q <= ovalid_d;
      mcnt_q   <= mcnt_d;
      dcnt_q   <= dcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    targ_q  <= targ_d;
    last_q  <= last_d;
    x_q     <= x_d;
    p_q     <= p_d;
    frac_q  <= frac_d;
    it_q    <= it_d;
    sel_q   <= sel_d;
    lnp_q   <= lnp_d;
    d_q     <= d_d;
    smag_q  <= smag_d;
    nsq_q   <= nsq_d;
    term2_q <= term2_d;
    term1_q <= term1_d;
    ma_q    <= ma_d;
    mb_q    <= mb_d;
    mh_q    <= mh_d;
    ml_q    <= ml_d;
    dr_q    <= dr_d;
    dq_q    <= dq_d;
    dv_q    <= dv_d;
    loss_q  <= loss_d;
    bad_q   <= bad_d;
  end

  always_comb begin
    state_d  = state_q;
    targ_d   = targ_q;
    last_d   = last_q;
    x_d      = x_q;
    p_d      = p_q;
    frac_d   = frac_q;
    it_d     = it_q;
    sel_d    = sel_q;
    lnp_d    = lnp_q;
    d_d      = d_q;
    dsum_d   = dsum_q;
    dsq_d    = dsq_q;
    err_d    = err_q;
    smag_d   = smag_q;
    nsq_d    = nsq_q;
    term2_d  = term2_q;
    term1_d  = term1_q;
    ma_d     = ma_q;
    mb_d     = mb_q;
    mh_d     = mh_q;
    ml_d     = ml_q;
    mcnt_d   = mcnt_q;
    dr_d     = dr_q;
    dq_d     = dq_q;
    dv_d     = dv_q;
    dcnt_d   = dcnt_q;
    loss_d   = loss_q;
    bad_d    = bad_q;
    ovalid_d = ovalid_q & ~m_axis_tready;

    // Advance the multiplier by one digit in every multiply state
    if ((state_q == S_SQ || state_q == S_SCALE || state_q == S_DSQ ||
         state_q == S_NSQ || state_q == S_GM1 || state_q == S_GM2) && !mul_done) begin
      mh_d   = mul_t[64:8];
      ml_d   = {mul_t[7:0], ml_q[MulBW-1:8]};
      mb_d   = mb_q >> 8;
      mcnt_d = mcnt_q + 3'd1;
    end

    // Advance the divider by one quotient bit
    if ((state_q == S_DIV1 || state_q == S_DIV2) && !div_done) begin
      dr_d   = div_ge ? 22'(div_rr - {1'b0, dv_q}) : div_rr[21:0];
      dq_d   = {dq_q[62:0], div_ge};
      dcnt_d = dcnt_q + 7'd1;
    end

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          targ_d = s_axis_tdata[63:32];
          last_d = s_axis_tlast;
          if (s_axis_tdata[31:0] == '0 || s_axis_tdata[63:32] == '0) begin
            err_d   = 1'b1;
            state_d = S_LAST;
          end else begin
            x_d     = s_axis_tdata[31:0];
            p_d     = 5'd31;
            sel_d   = 1'b0;
            state_d = S_NORM;
          end
        end
      end
      S_NORM: begin
        // Shift until the leading one sits at bit 31
        if (x_q[31]) begin
          ma_d    = MulAW'(x_q);
          mb_d    = MulBW'(x_q);
          mh_d    = '0;
          ml_d    = '0;
          mcnt_d  = '0;
          it_d    = '0;
          frac_d  = '0;
          state_d = S_SQ;
        end else begin
          x_d = x_q << 1;
          p_d = p_q - 5'd1;
        end
      end
      S_SQ: begin
        if (mul_done) begin
          x_d    = sq_m;
          frac_d = {frac_q[18:0], sq_bit};
          mh_d   = '0;
          ml_d   = '0;
          mcnt_d = '0;
          if (it_q == 5'(LogIters - 1)) begin
            ma_d    = MulAW'(Ln2Q32);
            mb_d    = MulBW'({p_q, frac_q[18:0], sq_bit});
            state_d = S_SCALE;
          end else begin
            ma_d = MulAW'(sq_m);
            mb_d = MulBW'(sq_m);
            it_d = it_q + 5'd1;
          end
        end
      end
      S_SCALE: begin
        if (mul_done) begin
          if (!sel_q) begin
            lnp_d   = ln_v;
            sel_d   = 1'b1;
            x_d     = targ_q;
            p_d     = 5'd31;
            state_d = S_NORM;
          end else begin
            d_d     = $signed({1'b0, lnp_q}) - $signed({1'b0, ln_v});
            state_d = S_DSQ;
            ma_d    = MulAW'(d_d[23] ? 23'(-d_d) : d_d[22:0]);
            mb_d    = MulBW'(d_d[23] ? 23'(-d_d) : d_d[22:0]);
            mh_d    = '0;
            ml_d    = '0;
            mcnt_d  = '0;
          end
        end
      end
      S_DSQ: begin
        if (mul_done) begin
          // Saturating accumulation of d and d*d
          if (dsum_s[40] != dsum_s[39]) begin
            dsum_d = dsum_s[40] ? {1'b1, 39'b0} : {1'b0, {39{1'b1}}};
          end else begin
            dsum_d = dsum_s[39:0];
          end
          dsq_d   = dsq_s[48] ? '1 : dsq_s[47:0];
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        if (!last_q) begin
          state_d = S_IDLE;
        end else begin
          smag_d  = dsum_q[39] ? 40'(-dsum_q) : dsum_q;
          ma_d    = MulAW'(num);
          mb_d    = MulBW'(num);
          mh_d    = '0;
          ml_d    = '0;
          mcnt_d  = '0;
          state_d = S_NSQ;
        end
      end
      S_NSQ: begin
        if (mul_done) begin
          nsq_d   = prod[21:0];
          ma_d    = MulAW'(smag_q);
          mb_d    = MulBW'(gm_q);
          mh_d    = '0;
          ml_d    = '0;
          mcnt_d  = '0;
          state_d = S_GM1;
        end
      end
      S_GM1: begin
        if (mul_done) begin
          ma_d    = prod[56:0];
          mb_d    = smag_q;
          mh_d    = '0;
          ml_d    = '0;
          mcnt_d  = '0;
          state_d = S_GM2;
        end
      end
      S_GM2: begin
        if (mul_done) begin
          // Drop the 2^32 scale before dividing by num^2
          dq_d    = prod[95:32];
          dr_d    = '0;
          dv_d    = nsq_q;
          dcnt_d  = '0;
          state_d = S_DIV2;
        end
      end
      S_DIV2: begin
        if (div_done) begin
          term2_d = dq_q;
          dq_d    = {16'b0, dsq_q};
          dr_d    = '0;
          dv_d    = 22'(num);
          dcnt_d  = '0;
          state_d = S_DIV1;
        end
      end
      S_DIV1: begin
        if (div_done) begin
          term1_d = dq_q[47:0];
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        // Hold until the output register is free
        if (!ovalid_q || m_axis_tready) begin
          if (loss_w > LossMax) begin
            loss_d = LossMax[47:0];
          end else if (loss_w < LossMin) begin
            loss_d = LossMin[47:0];
          end else begin
            loss_d = loss_w[47:0];
          end
          bad_d    = err_q;
          ovalid_d = 1'b1;
          dsum_d   = '0;
          dsq_d    = '0;
          err_d    = 1'b0;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
